### hw/rtl/assert_macros.svh
// Assertion macros shared by the converter modules.
// Each expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hw/rtl/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int NUM_CELLS = 8;

	localparam logic [7:0] OFF_GREEN = 8'd85;
	localparam logic [7:0] OFF_BLUE  = 8'd171;

	typedef enum logic {
		DIR_TO_HSV = 1'b0,
		DIR_TO_RGB = 1'b1
	} dir_t;

	typedef enum logic [2:0] {
		HUE_R0 = 3'd0,
		HUE_R1 = 3'd1,
		HUE_R2 = 3'd2,
		HUE_R3 = 3'd3,
		HUE_R4 = 3'd4,
		HUE_R5 = 3'd5
	} region_t;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] alpha_in;
	} pix_t;

	typedef struct packed {
		logic [7:0] out0;
		logic [7:0] out1;
		logic [7:0] out2;
		logic [7:0] alpha_out;
	} res_t;

	// One restoring-divider lane: partial remainder, dividend/quotient shifter, divisor
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] quo;
		logic [7:0] dvsr;
	} div_lane_t;

	// First front stage
	typedef struct packed {
		dir_t       dir;
		logic [7:0] alpha;
		logic [7:0] mx;
		logic [7:0] dlt;
		logic [7:0] mag;
		logic       neg;
		logic [7:0] off;
		region_t    region;
		logic [7:0] rem6;
		logic [7:0] sat;
		logic [7:0] val;
	} front_t;

	// Data moving along the cell chain
	typedef struct packed {
		div_lane_t  sat_lane;
		div_lane_t  hue_lane;
		dir_t       dir;
		logic [7:0] alpha;
		logic [7:0] val;
		logic       neg;
		logic [7:0] off;
		logic       zero;
		region_t    region;
		logic [7:0] pv;
		logic [7:0] qf;
		logic [7:0] tf;
	} cell_t;

	// Start of each hue region (region * 43)
	function automatic logic [7:0] region_base(region_t r);
		case (r)
			HUE_R0:  return 8'd0;
			HUE_R1:  return 8'd43;
			HUE_R2:  return 8'd86;
			HUE_R3:  return 8'd129;
			HUE_R4:  return 8'd172;
			default: return 8'd215;
		endcase
	endfunction

endpackage

### hw/rtl/rgb_hsv_color_converter.sv
`timescale 1ns / 1ps
// 8-bit RGB <-> HSV pixel converter (hue scaled 0..255, alpha passed through).
// Takes one pixel per clock while pix_ready is high and passes each through
// its registers in order before presenting the result on res: two front
// stages (max/min, region, dividends and first products), a chain of eight
// divider cells that each retire one quotient bit of the saturation and hue
// divisions, and one output register holding the final products and channel
// select. A stalled output holds up to 11 transactions before pix_ready drops.
// cfg_wdata picks the direction (0: RGB to HSV, 1: HSV to RGB) and must only
// be written while no transaction is in flight.

module rgb_hsv_color_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  rhc_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output rhc_pkg::res_t res
);

	rhc_pkg::dir_t  direction_q;
	rhc_pkg::cell_t cell_d [0:rhc_pkg::NUM_CELLS];
	logic           cell_v [0:rhc_pkg::NUM_CELLS];
	logic           cell_r [0:rhc_pkg::NUM_CELLS];

	// Direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) direction_q <= rhc_pkg::DIR_TO_HSV;
		else if (cfg_we) direction_q <= rhc_pkg::dir_t'(cfg_wdata);
	end

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dir      (direction_q),
		.up_valid (pix_valid),
		.up_ready (pix_ready),
		.up       (pix),
		.dn_valid (cell_v[0]),
		.dn_ready (cell_r[0]),
		.dn       (cell_d[0])
	);

	// Divider cell chain
	for (genvar i = 0; i < rhc_pkg::NUM_CELLS; i++) begin : g_cell
		rhc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cell_v[i]),
			.up_ready (cell_r[i]),
			.up       (cell_d[i]),
			.dn_valid (cell_v[i+1]),
			.dn_ready (cell_r[i+1]),
			.dn       (cell_d[i+1])
		);
	end

	rhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (cell_v[rhc_pkg::NUM_CELLS]),
		.up_ready  (cell_r[rhc_pkg::NUM_CELLS]),
		.up        (cell_d[rhc_pkg::NUM_CELLS]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

### hw/rtl/rhc_front.sv
`timescale 1ns / 1ps

module rhc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rhc_pkg::dir_t     dir,
	input  logic              up_valid,
	output logic              up_ready,
	input  rhc_pkg::pix_t     up,
	output logic              dn_valid,
	input  logic              dn_ready,
	output rhc_pkg::cell_t    dn
);

	rhc_pkg::front_t f_d, f_s1;
	rhc_pkg::cell_t  c_d, c_s2;
	logic            valid_s1, valid_s2;
	logic            rdy_s1, rdy_s2;

	logic [7:0]       r, g, b, mx, mn, hbase, hdiff;
	logic signed [8:0] num;
	logic [15:0]      n_sat, n_hue, prod_sr, prod_st, prod_p;

	// Handshake: a stage moves when empty or when its successor moves
	assign rdy_s2   = !valid_s2 || dn_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign dn_valid = valid_s2;
	assign dn       = c_s2;

	// Stage 1: max/min, sector, hue region
	always_comb begin
		r = up.chan0;
		g = up.chan1;
		b = up.chan2;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;

		// red wins ties, then green
		if (mx == r) begin
			f_d.off = 8'd0;
			num = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (mx == g) begin
			f_d.off = rhc_pkg::OFF_GREEN;
			num = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			f_d.off = rhc_pkg::OFF_BLUE;
			num = $signed({1'b0, r}) - $signed({1'b0, g});
		end

		f_d.dir   = dir;
		f_d.alpha = up.alpha_in;
		f_d.mx    = mx;
		f_d.dlt   = mx - mn;
		f_d.neg   = num[8];
		f_d.mag   = num[8] ? 8'(-num) : num[7:0];

		// hue region for the HSV input
		if (r >= 8'd215)      f_d.region = rhc_pkg::HUE_R5;
		else if (r >= 8'd172) f_d.region = rhc_pkg::HUE_R4;
		else if (r >= 8'd129) f_d.region = rhc_pkg::HUE_R3;
		else if (r >= 8'd86)  f_d.region = rhc_pkg::HUE_R2;
		else if (r >= 8'd43)  f_d.region = rhc_pkg::HUE_R1;
		else                  f_d.region = rhc_pkg::HUE_R0;
		hbase    = rhc_pkg::region_base(f_d.region);
		hdiff    = r - hbase;
		f_d.rem6 = {hdiff[5:0], 2'b00} + {1'b0, hdiff[5:0], 1'b0};
		f_d.sat  = g;
		f_d.val  = (dir == rhc_pkg::DIR_TO_RGB) ? b : mx;
	end

	// Stage 2: dividends and the first HSV products
	always_comb begin
		n_sat   = {f_s1.dlt, 8'b0} - {8'b0, f_s1.dlt};
		n_hue   = 16'({8'b0, f_s1.mag} * 16'd43);
		prod_sr = {8'b0, f_s1.sat} * {8'b0, f_s1.rem6};
		prod_st = {8'b0, f_s1.sat} * {8'b0, 8'd255 - f_s1.rem6};
		prod_p  = {8'b0, f_s1.val} * {8'b0, 8'd255 - f_s1.sat};

		c_d.sat_lane.rem  = n_sat[15:8];
		c_d.sat_lane.quo  = n_sat[7:0];
		c_d.sat_lane.dvsr = f_s1.mx;
		c_d.hue_lane.rem  = n_hue[15:8];
		c_d.hue_lane.quo  = n_hue[7:0];
		c_d.hue_lane.dvsr = f_s1.dlt;
		c_d.dir    = f_s1.dir;
		c_d.alpha  = f_s1.alpha;
		c_d.val    = f_s1.val;
		c_d.neg    = f_s1.neg;
		c_d.off    = f_s1.off;
		c_d.region = f_s1.region;
		c_d.zero   = (f_s1.dir == rhc_pkg::DIR_TO_RGB) ? (f_s1.sat == 8'd0)
		                                               : (f_s1.dlt == 8'd0);
		c_d.pv     = prod_p[15:8];
		c_d.qf     = 8'd255 - prod_sr[15:8];
		c_d.tf     = 8'd255 - prod_st[15:8];
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= up_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) f_s1 <= f_d;
		if (rdy_s2 && valid_s1) c_s2 <= c_d;
	end

endmodule

### hw/rtl/rhc_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rhc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rhc_pkg::cell_t up,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rhc_pkg::cell_t dn
);

	rhc_pkg::cell_t data_d, data_q;
	logic           valid_q;

	// One restoring step: shift in next dividend bit, subtract if it fits
	function automatic rhc_pkg::div_lane_t div_step(rhc_pkg::div_lane_t l);
		logic [8:0]         t;
		logic               ge;
		rhc_pkg::div_lane_t o;
		t      = {l.rem, l.quo[7]};
		ge     = (t >= {1'b0, l.dvsr});
		o.dvsr = l.dvsr;
		o.rem  = ge ? 8'(t - {1'b0, l.dvsr}) : t[7:0];
		o.quo  = {l.quo[6:0], ge};
		return o;
	endfunction

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn       = data_q;

	// Both lanes advance one quotient bit; side data rides along
	always_comb begin
		data_d          = up;
		data_d.sat_lane = div_step(up.sat_lane);
		data_d.hue_lane = div_step(up.hue_lane);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (up_ready) valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) data_q <= data_d;
	end

	// Partial remainder must stay below a nonzero divisor in an HSV transaction
	`AST_IMPLY(a_sat_rem, valid_q && data_q.dir == rhc_pkg::DIR_TO_HSV && data_q.sat_lane.dvsr != 8'd0, data_q.sat_lane.rem < data_q.sat_lane.dvsr)
	`AST_IMPLY(a_hue_rem, valid_q && data_q.dir == rhc_pkg::DIR_TO_HSV && !data_q.zero, data_q.hue_lane.rem < data_q.hue_lane.dvsr)

endmodule

### hw/rtl/rhc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rhc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rhc_pkg::cell_t up,
	output logic           res_valid,
	input  logic           res_ready,
	output rhc_pkg::res_t  res
);

	rhc_pkg::res_t res_d, res_q;
	rhc_pkg::dir_t dir_q;
	logic          valid_q;
	logic [15:0]   prod_q, prod_t;
	logic [7:0]    qv, tv, hq, hue;

	assign up_ready  = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	// Final products, region select, hue offset
	always_comb begin
		prod_q = {8'b0, up.val} * {8'b0, up.qf};
		prod_t = {8'b0, up.val} * {8'b0, up.tf};
		qv     = prod_q[15:8];
		tv     = prod_t[15:8];
		hq     = up.hue_lane.quo;
		hue    = up.off + (up.neg ? 8'(-hq) : hq);

		res_d.alpha_out = up.alpha;
		if (up.dir == rhc_pkg::DIR_TO_HSV) begin
			res_d.out2 = up.val;
			res_d.out1 = up.zero ? 8'd0 : up.sat_lane.quo;
			res_d.out0 = up.zero ? 8'd0 : hue;
		end else if (up.zero) begin
			res_d.out0 = up.val;
			res_d.out1 = up.val;
			res_d.out2 = up.val;
		end else begin
			case (up.region)
				rhc_pkg::HUE_R0: begin
					res_d.out0 = up.val; res_d.out1 = tv;     res_d.out2 = up.pv;
				end
				rhc_pkg::HUE_R1: begin
					res_d.out0 = qv;     res_d.out1 = up.val; res_d.out2 = up.pv;
				end
				rhc_pkg::HUE_R2: begin
					res_d.out0 = up.pv;  res_d.out1 = up.val; res_d.out2 = tv;
				end
				rhc_pkg::HUE_R3: begin
					res_d.out0 = up.pv;  res_d.out1 = qv;     res_d.out2 = up.val;
				end
				rhc_pkg::HUE_R4: begin
					res_d.out0 = tv;     res_d.out1 = up.pv;  res_d.out2 = up.val;
				end
				default: begin
					res_d.out0 = up.val; res_d.out1 = up.pv;  res_d.out2 = qv;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (up_ready) valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_q <= res_d;
			dir_q <= up.dir;
		end
	end

	// Hue quotient never exceeds one sector width
	`AST_IMPLY(a_hue_quo, up_valid && up.dir == rhc_pkg::DIR_TO_HSV && !up.zero, up.hue_lane.quo <= 8'd43)
	// Grey in HSV-to-RGB gives three equal channels
	`AST_NEXT(a_grey_rgb, up_valid && up_ready && up.dir == rhc_pkg::DIR_TO_RGB && up.zero, res_q.out0 == res_q.out1 && res_q.out1 == res_q.out2)
	// Zero saturation result carries zero hue
	`AST_IMPLY(a_sat_hue, valid_q && dir_q == rhc_pkg::DIR_TO_HSV && res_q.out1 == 8'd0, res_q.out0 == 8'd0)

endmodule
